>>> rtl/core/grq_pkg.sv
`timescale 1ns / 1ps
package grq_pkg;

   localparam int GRQ_MAX_COLS = 64;
   localparam int VALUE_W      = 32;
   localparam int FRAC_BITS    = 16;
   localparam int CODE_W       = 16;
   localparam int IDX_W        = 6;
   localparam int CSR_DATA_W   = 7;
   localparam int BITS_W       = 5;
   localparam int MAX_BITS     = 16;
   localparam int QUEUE_DEPTH  = 4;
   localparam int DIV_NUM_W    = 50;
   localparam int DIV_DEN_W    = 34;

   typedef enum logic [1:0] {
      CSR_QUANT_BITS = 2'd0,
      CSR_PROPAGATE  = 2'd1,
      CSR_PREFIX     = 2'd2,
      CSR_COLUMNS    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                    write_en;
      csr_index_type           index;
      logic [CSR_DATA_W-1:0]   data;
   } csr_write_type;

   typedef enum logic {
      OP_FACTOR = 1'b0,
      OP_WEIGHT = 1'b1
   } op_kind_type;

   typedef struct packed {
      op_kind_type                kind;
      logic                       write_en;
      logic                       row_end;
      logic [IDX_W-1:0]           row_index;
      logic [IDX_W-1:0]           col_index;
      logic signed [VALUE_W-1:0]  data_value;
   } queue_entry_type;

   typedef struct packed {
      logic                        start;
      logic signed [DIV_NUM_W-1:0] num;
      logic signed [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_GRID,
      ST_Q_RD,
      ST_Q_CHK,
      ST_Q_MUL1,
      ST_Q_DIV1,
      ST_Q_WAIT1,
      ST_Q_MUL2,
      ST_Q_DIV2,
      ST_Q_WAIT2,
      ST_Q_WRITE,
      ST_E_DIV,
      ST_E_WAIT,
      ST_U_RD,
      ST_U_MUL,
      ST_U_UPD,
      ST_Q_NEXT,
      ST_OUT_RD,
      ST_OUT_SEND
   } back_state_type;

   function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [63:0] v);
      logic signed [63:0] vmax;
      logic signed [63:0] vmin;
      vmax = (64'sd1 <<< (VALUE_W - 1)) - 64'sd1;
      vmin = -vmax - 64'sd1;
      if (v > vmax) begin
         return vmax[VALUE_W-1:0];
      end else if (v < vmin) begin
         return vmin[VALUE_W-1:0];
      end
      return v[VALUE_W-1:0];
   endfunction

endpackage

>>> rtl/core/grq_if.sv
`timescale 1ns / 1ps
interface grq_req_if;
   import grq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [IDX_W-1:0]          row_index;
   logic [IDX_W-1:0]          col_index;
   logic signed [VALUE_W-1:0] data_value;
   logic                      row_end;

   modport source(output valid, cmd, row_index, col_index, data_value, row_end, input ready);
   modport sink(input valid, cmd, row_index, col_index, data_value, row_end, output ready);
endinterface

interface grq_rsp_if;
   import grq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] weight_out;
   logic [CODE_W-1:0]         level_code;
   logic                      was_quantized;
   logic                      run_last;

   modport source(output valid, weight_out, level_code, was_quantized, run_last, input ready);
   modport sink(input valid, weight_out, level_code, was_quantized, run_last, output ready);
endinterface

>>> rtl/core/grq_front.sv
`timescale 1ns / 1ps
module grq_front #(
   parameter int MAX_COLS = grq_pkg::GRQ_MAX_COLS
) (
   grq_req_if.sink                   req,
   input  logic                      q_full,
   output logic                      q_push,
   output grq_pkg::queue_entry_type  q_entry
);
   import grq_pkg::*;

   localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(MAX_COLS);

   logic accept;
   logic row_ok;
   logic col_ok;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign row_ok    = {1'b0, req.row_index} < LIMIT;
   assign col_ok    = {1'b0, req.col_index} < LIMIT;

   always_comb begin
      q_entry.kind       = req.cmd ? OP_WEIGHT : OP_FACTOR;
      q_entry.write_en   = req.cmd ? col_ok : (row_ok && col_ok);
      q_entry.row_end    = req.cmd && req.row_end;
      q_entry.row_index  = req.row_index;
      q_entry.col_index  = req.col_index;
      q_entry.data_value = req.data_value;
   end

   // drop transactions that neither write nor start a sweep
   assign q_push = accept && (q_entry.write_en || q_entry.row_end);

endmodule

>>> rtl/core/grq_queue.sv
`timescale 1ns / 1ps
module grq_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  grq_pkg::queue_entry_type  push_entry,
   input  logic                      pop,
   output grq_pkg::queue_entry_type  pop_entry,
   output logic                      full,
   output logic                      empty
);
   import grq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/grq_div.sv
`timescale 1ns / 1ps
module grq_div (
   input  logic                                clock,
   input  logic                                reset,
   input  grq_pkg::div_req_type                req,
   output logic                                busy,
   output logic                                done,
   output logic signed [grq_pkg::DIV_NUM_W:0]  quot
);
   import grq_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);
   localparam int MAG_W = DIV_DEN_W - 1;

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  neg_ff;
   logic [DIV_NUM_W-1:0]  quo_ff;
   logic [MAG_W-1:0]      den_ff;
   logic [MAG_W-1:0]      rem_ff;

   logic [DIV_NUM_W-1:0]  num_mag;
   logic [MAG_W-1:0]      den_mag;
   logic [DIV_DEN_W-1:0]  den_abs;
   logic [DIV_NUM_W-1:0]  num_abs;
   logic [MAG_W:0]        trial;
   logic                  fits;

   assign num_abs = req.num[DIV_NUM_W-1] ? DIV_NUM_W'(-req.num) : DIV_NUM_W'(req.num);
   assign den_abs = req.den[DIV_DEN_W-1] ? DIV_DEN_W'(-req.den) : DIV_DEN_W'(req.den);
   assign den_mag = den_abs[MAG_W-1:0];
   // bias by half the divisor so that the floor quotient rounds to nearest
   assign num_mag = num_abs + DIV_NUM_W'(den_mag >> 1);

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         neg_ff <= req.num[DIV_NUM_W-1] ^ req.den[DIV_DEN_W-1];
         quo_ff <= num_mag;
         den_ff <= den_mag;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? MAG_W'(trial - {1'b0, den_ff}) : trial[MAG_W-1:0];
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

endmodule

>>> rtl/core/grq_back.sv
`timescale 1ns / 1ps
module grq_back #(
   parameter int MAX_COLS = grq_pkg::GRQ_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  grq_pkg::csr_write_type              csr,
   input  logic                                q_empty,
   input  grq_pkg::queue_entry_type            q_entry,
   output logic                                q_pop,
   output grq_pkg::div_req_type                div_req,
   input  logic                                div_done,
   input  logic signed [grq_pkg::DIV_NUM_W:0]  div_quot,
   grq_rsp_if.source                           rsp
);
   import grq_pkg::*;

   localparam int CI_W  = $clog2(MAX_COLS);
   localparam int CNT_W = $clog2(MAX_COLS + 1);
   localparam int FA_W  = $clog2(MAX_COLS * MAX_COLS);

   back_state_type state_ff, state_in;

   logic [BITS_W-1:0]      bits_cfg_ff;
   logic                   prop_cfg_ff;
   logic [CSR_DATA_W-1:0]  prefix_cfg_ff;
   logic [CSR_DATA_W-1:0]  cols_cfg_ff;

   logic [CSR_DATA_W-1:0]  cols_eff;
   logic [CSR_DATA_W-1:0]  prefix_eff;
   logic [BITS_W-1:0]      bits_eff;
   logic [CODE_W:0]        maxcode_eff;

   logic [CNT_W-1:0]       cols_ff;
   logic [CNT_W-1:0]       prefix_ff;
   logic [BITS_W-1:0]      bits_ff;
   logic                   prop_ff;
   logic [CODE_W-1:0]      maxcode_ff;
   logic [CNT_W-1:0]       idx_ff;
   logic [CNT_W-1:0]       j_ff;
   logic [CNT_W-1:0]       k_ff;

   logic signed [VALUE_W-1:0] lo_ff;
   logic signed [VALUE_W-1:0] hi_ff;
   logic signed [VALUE_W-1:0] zero_ff;
   logic [VALUE_W-1:0]        span_ff;
   logic signed [VALUE_W-1:0] w_ff;
   logic signed [VALUE_W-1:0] q_ff;
   logic signed [VALUE_W-1:0] ujj_ff;
   logic signed [VALUE_W-1:0] err_ff;
   logic signed [VALUE_W-1:0] wk_ff;
   logic [CODE_W-1:0]         t_ff;
   logic signed [63:0]        prod_ff;

   logic signed [VALUE_W-1:0] wmem [MAX_COLS];
   logic signed [VALUE_W-1:0] fmem [MAX_COLS * MAX_COLS];
   logic [CODE_W-1:0]         cmem [MAX_COLS];
   logic signed [VALUE_W-1:0] w_rd_ff;
   logic signed [VALUE_W-1:0] f_rd_ff;
   logic [CODE_W-1:0]         c_rd_ff;

   logic                      w_re;
   logic [CI_W-1:0]           w_raddr;
   logic                      w_we;
   logic [CI_W-1:0]           w_waddr;
   logic signed [VALUE_W-1:0] w_wdata;
   logic                      c_we;
   logic                      f_re;
   logic [FA_W-1:0]           f_raddr;
   logic                      f_we;
   logic [FA_W-1:0]           f_waddr;
   logic                      out_load;
   logic                      out_free;

   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] out_weight_ff;
   logic [CODE_W-1:0]         out_code_ff;
   logic                      out_quant_ff;
   logic                      out_last_ff;

   logic signed [VALUE_W:0]   w_minus_lo;
   logic signed [VALUE_W:0]   w_minus_q;
   logic signed [49:0]        mul_grid;
   logic [47:0]               mul_level;
   logic signed [63:0]        mul_err;
   logic [63:0]               prod_mag;
   logic [47:0]               term_mag;
   logic signed [63:0]        term;
   logic signed [VALUE_W-1:0] upd_value;
   logic signed [VALUE_W-1:0] err_sat;
   logic [CNT_W-1:0]          j_next;
   logic [CNT_W-1:0]          k_next;
   logic [CNT_W-1:0]          idx_next;
   logic                      needs_comp;

   assign cols_eff = (cols_cfg_ff == '0) ? CSR_DATA_W'(1) :
                     ((int'(cols_cfg_ff) > MAX_COLS) ? CSR_DATA_W'(MAX_COLS) : cols_cfg_ff);
   assign prefix_eff  = (prefix_cfg_ff > cols_eff) ? cols_eff : prefix_cfg_ff;
   assign bits_eff    = (int'(bits_cfg_ff) > MAX_BITS) ? BITS_W'(MAX_BITS) : bits_cfg_ff;
   assign maxcode_eff = ((CODE_W + 1)'(1) << bits_eff) - (CODE_W + 1)'(1);

   assign w_minus_lo = (VALUE_W + 1)'(w_ff) - (VALUE_W + 1)'(zero_ff);
   assign w_minus_q  = (VALUE_W + 1)'(w_ff) - (VALUE_W + 1)'(q_ff);
   assign mul_grid   = w_minus_lo * $signed({1'b0, maxcode_ff});
   assign mul_level  = 48'(t_ff) * 48'(span_ff);
   assign mul_err    = 64'(err_ff) * 64'(f_rd_ff);

   assign prod_mag  = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign term_mag  = 48'((prod_mag + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
   assign term      = prod_ff[63] ? -$signed(64'(term_mag)) : $signed(64'(term_mag));
   assign upd_value = sat_value(64'(wk_ff) - term);
   assign err_sat   = sat_value(64'(div_quot));

   assign j_next     = j_ff + 1'b1;
   assign k_next     = k_ff + 1'b1;
   assign idx_next   = idx_ff + 1'b1;
   assign needs_comp = prop_ff && (ujj_ff != '0) && (w_ff != q_ff);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      w_re        = 1'b0;
      w_raddr     = idx_ff[CI_W-1:0];
      w_we        = 1'b0;
      w_waddr     = j_ff[CI_W-1:0];
      w_wdata     = q_ff;
      c_we        = 1'b0;
      f_re        = 1'b0;
      f_raddr     = FA_W'(FA_W'(j_ff[CI_W-1:0]) * FA_W'(MAX_COLS) + FA_W'(j_ff[CI_W-1:0]));
      f_we        = 1'b0;
      f_waddr     = FA_W'(FA_W'(q_entry.row_index) * FA_W'(MAX_COLS)
                          + FA_W'(q_entry.col_index));
      div_req.start = 1'b0;
      div_req.num   = prod_ff[DIV_NUM_W-1:0];
      div_req.den   = DIV_DEN_W'(span_ff);
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_entry.kind == OP_FACTOR) begin
                  f_we = q_entry.write_en;
               end else begin
                  w_we    = q_entry.write_en;
                  w_waddr = q_entry.col_index[CI_W-1:0];
                  w_wdata = q_entry.data_value;
                  if (q_entry.row_end) begin
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            w_re     = 1'b1;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = (idx_next == cols_ff) ? ST_GRID : ST_SCAN_RD;
         end
         ST_GRID: begin
            state_in = (prefix_ff == '0) ? ST_OUT_RD : ST_Q_RD;
         end
         ST_Q_RD: begin
            w_re     = 1'b1;
            w_raddr  = j_ff[CI_W-1:0];
            f_re     = 1'b1;
            state_in = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            if (bits_ff == '0 || span_ff == '0) begin
               state_in = ST_Q_WRITE;
            end else begin
               state_in = ST_Q_MUL1;
            end
         end
         ST_Q_MUL1: begin
            state_in = ST_Q_DIV1;
         end
         ST_Q_DIV1: begin
            if (prod_ff[63]) begin
               state_in = ST_Q_MUL2;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_Q_WAIT1;
            end
         end
         ST_Q_WAIT1: begin
            if (div_done) begin
               state_in = ST_Q_MUL2;
            end
         end
         ST_Q_MUL2: begin
            state_in = ST_Q_DIV2;
         end
         ST_Q_DIV2: begin
            div_req.start = 1'b1;
            div_req.den   = DIV_DEN_W'(maxcode_ff);
            state_in      = ST_Q_WAIT2;
         end
         ST_Q_WAIT2: begin
            if (div_done) begin
               state_in = ST_Q_WRITE;
            end
         end
         ST_Q_WRITE: begin
            w_we     = 1'b1;
            c_we     = 1'b1;
            state_in = needs_comp ? ST_E_DIV : ST_Q_NEXT;
         end
         ST_E_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = {w_minus_q[VALUE_W], w_minus_q, FRAC_BITS'(0)};
            div_req.den   = DIV_DEN_W'(ujj_ff);
            state_in      = ST_E_WAIT;
         end
         ST_E_WAIT: begin
            if (div_done) begin
               if (err_sat == '0 || j_next == cols_ff) begin
                  state_in = ST_Q_NEXT;
               end else begin
                  state_in = ST_U_RD;
               end
            end
         end
         ST_U_RD: begin
            w_re     = 1'b1;
            w_raddr  = k_ff[CI_W-1:0];
            f_re     = 1'b1;
            f_raddr  = FA_W'(FA_W'(j_ff[CI_W-1:0]) * FA_W'(MAX_COLS) + FA_W'(k_ff[CI_W-1:0]));
            state_in = ST_U_MUL;
         end
         ST_U_MUL: begin
            state_in = ST_U_UPD;
         end
         ST_U_UPD: begin
            w_we     = 1'b1;
            w_waddr  = k_ff[CI_W-1:0];
            w_wdata  = upd_value;
            state_in = (k_next == cols_ff) ? ST_Q_NEXT : ST_U_RD;
         end
         ST_Q_NEXT: begin
            state_in = (j_next == prefix_ff) ? ST_OUT_RD : ST_Q_RD;
         end
         ST_OUT_RD: begin
            w_re     = 1'b1;
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = (idx_next == cols_ff) ? ST_IDLE : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bits_cfg_ff   <= BITS_W'(4);
         prop_cfg_ff   <= 1'b1;
         prefix_cfg_ff <= CSR_DATA_W'(64);
         cols_cfg_ff   <= CSR_DATA_W'(64);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr.write_en) begin
            case (csr.index)
               CSR_QUANT_BITS: bits_cfg_ff   <= csr.data[BITS_W-1:0];
               CSR_PROPAGATE:  prop_cfg_ff   <= csr.data[0];
               CSR_PREFIX:     prefix_cfg_ff <= csr.data;
               CSR_COLUMNS:    cols_cfg_ff   <= csr.data;
               default:        bits_cfg_ff   <= bits_cfg_ff;
            endcase
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cols_ff    <= CNT_W'(cols_eff);
            prefix_ff  <= CNT_W'(prefix_eff);
            bits_ff    <= bits_eff;
            prop_ff    <= prop_cfg_ff;
            maxcode_ff <= maxcode_eff[CODE_W-1:0];
            idx_ff     <= '0;
         end
         ST_SCAN_CMP: begin
            if (idx_ff == '0 || w_rd_ff < lo_ff) begin
               lo_ff <= w_rd_ff;
            end
            if (idx_ff == '0 || w_rd_ff > hi_ff) begin
               hi_ff <= w_rd_ff;
            end
            idx_ff <= idx_next;
         end
         ST_GRID: begin
            if (bits_ff == '0) begin
               zero_ff <= '0;
               span_ff <= '0;
            end else begin
               zero_ff <= lo_ff;
               span_ff <= VALUE_W'(hi_ff - lo_ff);
            end
            j_ff   <= '0;
            idx_ff <= '0;
         end
         ST_Q_CHK: begin
            w_ff   <= w_rd_ff;
            ujj_ff <= f_rd_ff;
            t_ff   <= '0;
            q_ff   <= (bits_ff == '0) ? w_rd_ff : zero_ff;
         end
         ST_Q_MUL1: begin
            prod_ff <= 64'(mul_grid);
         end
         ST_Q_WAIT1: begin
            if (div_done) begin
               if (div_quot > $signed({(DIV_NUM_W - CODE_W + 1)'(0), maxcode_ff})) begin
                  t_ff <= maxcode_ff;
               end else begin
                  t_ff <= div_quot[CODE_W-1:0];
               end
            end
         end
         ST_Q_MUL2: begin
            prod_ff <= $signed(64'(mul_level));
         end
         ST_Q_WAIT2: begin
            if (div_done) begin
               q_ff <= zero_ff + $signed(div_quot[VALUE_W-1:0]);
            end
         end
         ST_E_WAIT: begin
            if (div_done) begin
               err_ff <= err_sat;
               k_ff   <= j_next;
            end
         end
         ST_U_MUL: begin
            prod_ff <= mul_err;
            wk_ff   <= w_rd_ff;
         end
         ST_U_UPD: begin
            k_ff <= k_next;
         end
         ST_Q_NEXT: begin
            j_ff <= j_next;
         end
         ST_OUT_SEND: begin
            if (out_free) begin
               idx_ff        <= idx_next;
               out_weight_ff <= w_rd_ff;
               out_code_ff   <= (idx_ff < prefix_ff) ? c_rd_ff : '0;
               out_quant_ff  <= idx_ff < prefix_ff;
               out_last_ff   <= idx_next == cols_ff;
            end
         end
         default: begin
            idx_ff <= idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      if (c_we) begin
         cmem[w_waddr] <= t_ff;
      end
      if (w_re) begin
         w_rd_ff <= wmem[w_raddr];
         c_rd_ff <= cmem[w_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fmem[f_waddr] <= q_entry.data_value;
      end
      if (f_re) begin
         f_rd_ff <= fmem[f_raddr];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.weight_out    = out_weight_ff;
   assign rsp.level_code    = out_code_ff;
   assign rsp.was_quantized = out_quant_ff;
   assign rsp.run_last      = out_last_ff;

endmodule

>>> rtl/core/gptq_row_quantizer.sv
`timescale 1ns / 1ps
// Row quantizer with error compensation on signed Q16.16 values. Factor entries and
// row weights are taken one transaction a cycle into a four-entry queue, so loads
// stream at one per cycle while the queue has room. The weight transaction that ends
// a row starts a sweep in the back end: a min/max scan of the row memory, then for
// each quantized column up to three 50-step divisions for code, level and error in
// the shared bit-serial divider (one quotient bit a cycle), plus a read, multiply and
// update step per later column that the error updates, then a read and a send step
// per emitted result. The output register lets the next row start loading while the
// last result still waits to be taken. Factor and row entries must be written before
// they are read; there is no clearing pass.
module gptq_row_quantizer #(
   parameter int MAX_COLS = grq_pkg::GRQ_MAX_COLS
) (
   input  logic                             clock,
   input  logic                             reset,
   grq_req_if.sink                          req_chan,
   grq_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_en,
   input  grq_pkg::csr_index_type           csr_index,
   input  logic [grq_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import grq_pkg::*;

   logic                       q_push;
   logic                       q_pop;
   logic                       q_full;
   logic                       q_empty;
   queue_entry_type            push_entry;
   queue_entry_type            pop_entry;
   csr_write_type              csr;
   div_req_type                div_req;
   logic                       div_busy;
   logic                       div_done;
   logic signed [DIV_NUM_W:0]  div_quot;

   assign csr.write_en = csr_write_en;
   assign csr.index    = csr_index;
   assign csr.data     = csr_write_data;

   grq_front #(.MAX_COLS(MAX_COLS)) u_front (
      .req     (req_chan),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   grq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   grq_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   grq_back #(.MAX_COLS(MAX_COLS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .q_empty  (q_empty),
      .q_entry  (pop_entry),
      .q_pop    (q_pop),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot),
      .rsp      (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue pop while empty");
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !div_busy)
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset) div_done |-> !div_req.start)
      else $error("divider restarted on completion");

endmodule
